>>> rtl/core/ckblit_pkg.sv
package ckblit_pkg;

  localparam int unsigned PixelBits  = 16;
  localparam int unsigned DimBits    = 12;
  localparam int unsigned PosBits    = 13;
  localparam int unsigned OffsetBits = 24;
  localparam int unsigned IndexBits  = 4;
  localparam int unsigned CfgBits    = 16;
  localparam int unsigned CoordBits  = 15;

  localparam logic [IndexBits-1:0] REG_X_POSITION     = 4'd0;
  localparam logic [IndexBits-1:0] REG_Y_POSITION     = 4'd1;
  localparam logic [IndexBits-1:0] REG_IMAGE_WIDTH    = 4'd2;
  localparam logic [IndexBits-1:0] REG_IMAGE_HEIGHT   = 4'd3;
  localparam logic [IndexBits-1:0] REG_ALIGNMENT_MODE = 4'd4;
  localparam logic [IndexBits-1:0] REG_SCREEN_COLUMNS = 4'd5;
  localparam logic [IndexBits-1:0] REG_SCREEN_ROWS    = 4'd6;
  localparam logic [IndexBits-1:0] REG_COLOR_KEY      = 4'd7;

  localparam logic [1:0] ALIGN_LEFT = 2'd0;
  localparam logic [1:0] ALIGN_HALF = 2'd1;
  localparam logic [1:0] ALIGN_FULL = 2'd2;

  typedef struct packed {
    logic signed [PosBits-1:0] x_position;
    logic signed [PosBits-1:0] y_position;
    logic [DimBits-1:0]        image_width;
    logic [DimBits-1:0]        image_height;
    logic [1:0]                alignment_mode;
    logic [DimBits-1:0]        screen_columns;
    logic [DimBits-1:0]        screen_rows;
    logic [PixelBits-1:0]      color_key;
  } cfg_t;

  typedef struct packed {
    logic [PixelBits-1:0] pixel;
    logic [DimBits-1:0]   row;
    logic [DimBits-1:0]   col;
    logic [DimBits-1:0]   columns;
    logic                 on_screen;
    logic                 opaque;
    logic                 last;
  } coord_t;

endpackage

>>> rtl/core/ckblit_regs.sv
module ckblit_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [ckblit_pkg::IndexBits-1:0] wr_index,
  input  logic [ckblit_pkg::CfgBits-1:0]   wr_data,
  output ckblit_pkg::cfg_t                 cfg,
  output logic                             restart
);

  ckblit_pkg::cfg_t cfg_r;
  ckblit_pkg::cfg_t cfg_nxt;
  logic             hit;

  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b0;
    if (wr_en) begin
      hit = 1'b1;
      unique case (wr_index)
        ckblit_pkg::REG_X_POSITION:     cfg_nxt.x_position     = $signed(wr_data[12:0]);
        ckblit_pkg::REG_Y_POSITION:     cfg_nxt.y_position     = $signed(wr_data[12:0]);
        ckblit_pkg::REG_IMAGE_WIDTH:    cfg_nxt.image_width    = wr_data[11:0];
        ckblit_pkg::REG_IMAGE_HEIGHT:   cfg_nxt.image_height   = wr_data[11:0];
        ckblit_pkg::REG_ALIGNMENT_MODE: cfg_nxt.alignment_mode = wr_data[1:0];
        ckblit_pkg::REG_SCREEN_COLUMNS: cfg_nxt.screen_columns = wr_data[11:0];
        ckblit_pkg::REG_SCREEN_ROWS:    cfg_nxt.screen_rows    = wr_data[11:0];
        ckblit_pkg::REG_COLOR_KEY:      cfg_nxt.color_key      = wr_data[15:0];
        default:                        hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_position     <= 13'sd0;
      cfg_r.y_position     <= 13'sd0;
      cfg_r.image_width    <= 12'd1;
      cfg_r.image_height   <= 12'd1;
      cfg_r.alignment_mode <= ckblit_pkg::ALIGN_LEFT;
      cfg_r.screen_columns <= 12'd1024;
      cfg_r.screen_rows    <= 12'd768;
      cfg_r.color_key      <= 16'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign restart = hit;

endmodule

>>> rtl/core/ckblit_coord.sv
module ckblit_coord (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ckblit_pkg::cfg_t                 cfg,
  input  logic                             restart,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ckblit_pkg::PixelBits-1:0] in_pixel,
  output logic                             s1_valid,
  input  logic                             s1_ready,
  output ckblit_pkg::coord_t               s1_data
);

  localparam int unsigned DB = ckblit_pkg::DimBits;
  localparam int unsigned CB = ckblit_pkg::CoordBits;

  logic [DB-1:0]       col_r, col_nxt;
  logic [DB-1:0]       row_r, row_nxt;
  logic                valid_r, valid_nxt;
  ckblit_pkg::coord_t  data_r, data_nxt;

  logic [DB-1:0]        w, h;
  logic [DB:0]          adjust;
  logic signed [CB-1:0] anchor_x, sc, sr;
  logic                 load;
  logic                 col_wrap, row_wrap;

  assign in_ready = !valid_r || s1_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    w = (cfg.image_width == '0) ? DB'(1) : cfg.image_width;
    h = (cfg.image_height == '0) ? DB'(1) : cfg.image_height;
    case (cfg.alignment_mode)
      ckblit_pkg::ALIGN_HALF: adjust = {1'b0, w >> 1};
      ckblit_pkg::ALIGN_FULL: adjust = {1'b0, w};
      default:                adjust = '0;
    endcase
    anchor_x = CB'(cfg.x_position) - $signed(CB'(adjust));
    sc = anchor_x + $signed(CB'(col_r));
    sr = CB'(cfg.y_position) + $signed(CB'(h)) - $signed(CB'(1)) - $signed(CB'(row_r));

    data_nxt.pixel     = in_pixel;
    data_nxt.row       = sr[DB-1:0];
    data_nxt.col       = sc[DB-1:0];
    data_nxt.columns   = cfg.screen_columns;
    data_nxt.on_screen = !sc[CB-1] && (sc[CB-2:0] < (CB-1)'(cfg.screen_columns))
                      && !sr[CB-1] && (sr[CB-2:0] < (CB-1)'(cfg.screen_rows));
    data_nxt.opaque    = in_pixel != cfg.color_key;
    data_nxt.last      = (col_r >= w - DB'(1)) && (row_r >= h - DB'(1));

    col_wrap = ({1'b0, col_r} + (DB+1)'(1)) >= {1'b0, w};
    row_wrap = ({1'b0, row_r} + (DB+1)'(1)) >= {1'b0, h};

    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (load) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + DB'(1);
      end else begin
        col_nxt = col_r + DB'(1);
      end
    end

    if (load) begin
      valid_nxt = 1'b1;
    end else if (s1_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

>>> rtl/core/ckblit_out.sv
module ckblit_out (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s1_valid,
  output logic                              s1_ready,
  input  ckblit_pkg::coord_t                s1_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ckblit_pkg::OffsetBits-1:0] out_offset,
  output logic [ckblit_pkg::PixelBits-1:0]  out_pixel,
  output logic                              out_write,
  output logic                              out_last
);

  localparam int unsigned OB = ckblit_pkg::OffsetBits;

  logic                                valid_r, valid_nxt;
  logic [OB-1:0]                       offset_r, offset_nxt;
  logic [ckblit_pkg::PixelBits-1:0]    pixel_r;
  logic                                write_r, last_r;
  logic                                load;

  assign s1_ready = !valid_r || out_ready;
  assign load     = s1_valid && s1_ready;

  always_comb begin
    offset_nxt = '0;
    if (s1_data.on_screen) begin
      offset_nxt = OB'(s1_data.row) * OB'(s1_data.columns) + OB'(s1_data.col);
    end
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      offset_r <= offset_nxt;
      pixel_r  <= s1_data.pixel;
      write_r  <= s1_data.on_screen && s1_data.opaque;
      last_r   <= s1_data.last;
    end
  end

  assign out_valid  = valid_r;
  assign out_offset = offset_r;
  assign out_pixel  = pixel_r;
  assign out_write  = write_r;
  assign out_last   = last_r;

endmodule

>>> rtl/core/color_key_sprite_blit_core.sv
// Colour-key sprite blitter. Source pixels of a bottom-up image arrive one per request on the
// input stream, rows bottom-up and columns left to right; each yields one result carrying the
// framebuffer offset (row times screen columns plus column), the pixel, a write flag in tuser
// that is set only when the target is on screen and the pixel differs from the colour key, and
// tlast on the final pixel of the image. A request is taken every clock unless out_tready stalls
// the output; one register stage forms the clipped screen coordinates from the column and row
// counters, the next forms the offset with a single 12 by 12 bit multiply. A configuration
// write to register index 0 to 7 restarts the image at its first pixel and should be made while idle.
module color_key_sprite_blit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] source_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [23:0] fb_offset, [39:24] pixel_out
  output logic        out_tuser,  // [0] write_enable
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ckblit_pkg::cfg_t   cfg;
  logic               restart;
  logic               s1_valid;
  logic               s1_ready;
  ckblit_pkg::coord_t s1_data;
  logic [23:0]        offset;
  logic [15:0]        pixel;

  assign cfg_ready = 1'b1;

  ckblit_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .restart  (restart)
  );

  ckblit_coord u_coord (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .restart  (restart),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pixel (in_tdata),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data)
  );

  ckblit_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_data    (s1_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_offset (offset),
    .out_pixel  (pixel),
    .out_write  (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {pixel, offset};

endmodule
